// ===== src/aniso_lookup_texel_generator_unit_macros.svh =====
`ifndef ANISO_LOOKUP_TEXEL_GENERATOR_UNIT_MACROS_SVH
`define ANISO_LOOKUP_TEXEL_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ALT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ALT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/alt_pkg.sv =====
package alt_pkg;

    localparam int MAX_TEX_SIZE_DEF = 1024;
    localparam int Q_DEPTH_DEF      = 4;

    // Q2.16 values, unsigned.
    typedef logic [17:0] t_q;

    localparam t_q ONE_Q  = 18'd65536;
    localparam t_q K_SPEC = 18'd52429;
    localparam t_q K_DIFF = 18'd13107;

    typedef enum logic [2:0] {
        REG_TEXTURE_SIZE = 3'd0,
        REG_TINT_RED     = 3'd1,
        REG_TINT_GREEN   = 3'd2,
        REG_TINT_BLUE    = 3'd3,
        REG_TINT_ALPHA   = 3'd4,
        REG_METAL_MODE   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [10:0] texture_size;
        logic [7:0]  tint_red;
        logic [7:0]  tint_green;
        logic [7:0]  tint_blue;
        logic [7:0]  tint_alpha;
        logic        metal_mode;
    } t_cfg;

    function automatic t_q qmul(input t_q a, input t_q b);
        logic [35:0] p;
        p = 36'(a) * 36'(b);
        return p[33:16];
    endfunction

    // (t * 65536 + 127) / 255 equals 257 * t plus one when t is 128 or more.
    function automatic t_q chan_q(input logic [7:0] t);
        return 18'({t, 8'h00}) + 18'(t) + 18'(t[7]);
    endfunction

    // Argument of the circle square root: (1 - min(a2, 1)) << 16.
    function automatic logic [32:0] circ_arg(input t_q a2);
        t_q a2c;
        a2c = (a2 > ONE_Q) ? ONE_Q : a2;
        return 33'(ONE_Q - a2c) << 16;
    endfunction

    // Specular base su*cv -/+ u*v, clamped to [0, 1].
    function automatic t_q spec_base(input t_q pp, input t_q uvm, input logic dif);
        logic [18:0] s;
        if (dif) begin
            s = 19'(pp) + 19'(uvm);
        end else if (pp < uvm) begin
            s = '0;
        end else begin
            s = 19'(pp) - 19'(uvm);
        end
        if (s > 19'(ONE_Q)) begin
            s = 19'(ONE_Q);
        end
        return s[17:0];
    endfunction

    function automatic logic [7:0] scale8(input t_q v);
        t_q          vc;
        logic [25:0] m;
        vc = (v > ONE_Q) ? ONE_Q : v;
        m  = {vc, 8'h00} - 26'(vc);
        return m[23:16];
    endfunction

endpackage

// ===== src/alt_front.sv =====
module alt_front #(
    parameter int MAX_TEX_SIZE = alt_pkg::MAX_TEX_SIZE_DEF,
    parameter int DW           = $clog2(MAX_TEX_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  alt_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [9:0]    i_texel_x,
    input  logic [9:0]    i_texel_y,
    input  logic          i_full,
    output logic          o_push,
    output logic [DW-1:0] o_den,
    output logic [DW-1:0] o_mu,
    output logic [DW-1:0] o_mv,
    output logic          o_uneg,
    output logic          o_vneg
);

    localparam logic [12:0] MAXS = 13'(MAX_TEX_SIZE);

    logic [12:0]   s_size;
    logic [DW-1:0] s_d;
    logic [DW-1:0] s_x;
    logic [DW-1:0] s_y;
    logic [DW:0]   s_tx;
    logic [DW:0]   s_ty;
    logic [DW:0]   s_dd;
    logic          s_uneg;
    logic          s_vneg;
    logic [DW:0]   s_mu;
    logic [DW:0]   s_mv;

    logic          r_vld;
    logic [DW-1:0] r_mu;
    logic [DW-1:0] r_mv;
    logic          r_uneg;
    logic          r_vneg;

    always_comb begin
        s_size = {2'b00, i_cfg.texture_size};
        if (s_size < 13'd2) begin
            s_size = 13'd2;
        end else if (s_size > MAXS) begin
            s_size = MAXS;
        end
        s_d = DW'(s_size - 13'd1);

        // Coordinates past the edge are saturated to the last texel.
        s_x = (13'(i_texel_x) > 13'(s_d)) ? s_d : DW'(i_texel_x);
        s_y = (13'(i_texel_y) > 13'(s_d)) ? s_d : DW'(i_texel_y);

        s_tx   = {s_x, 1'b0};
        s_ty   = {s_y, 1'b0};
        s_dd   = {1'b0, s_d};
        s_uneg = s_tx < s_dd;
        s_vneg = s_ty > s_dd;
        s_mu   = s_uneg ? (s_dd - s_tx) : (s_tx - s_dd);
        s_mv   = s_vneg ? (s_ty - s_dd) : (s_dd - s_ty);
    end

    assign o_stall = r_vld && i_full;
    assign o_push  = r_vld && !i_full;
    assign o_den   = s_d;
    assign o_mu    = r_mu;
    assign o_mv    = r_mv;
    assign o_uneg  = r_uneg;
    assign o_vneg  = r_vneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_mu   <= s_mu[DW-1:0];
            r_mv   <= s_mv[DW-1:0];
            r_uneg <= s_uneg;
            r_vneg <= s_vneg;
        end
    end

endmodule

// ===== src/alt_queue.sv =====
module alt_queue #(
    parameter int W     = 8,
    parameter int DEPTH = alt_pkg::Q_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          s_push;
    logic          s_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (s_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== src/alt_div.sv =====
// Restoring divider, one quotient bit per stage: floor((num << 16) / den), num <= den.
module alt_div #(
    parameter int DW = 10
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [16:0]   o_quot
);

    logic [DW-1:0] r_rem [17];
    logic [16:0]   r_q   [17];

    for (genvar k = 0; k < 17; k++) begin : g_stage
        localparam int I = 16 - k;
        logic [DW:0] s_t;
        logic [DW:0] s_sub;
        logic [16:0] s_qin;
        logic        s_ge;

        if (k == 0) begin : g_first
            assign s_t   = {1'b0, i_num};
            assign s_qin = '0;
        end else begin : g_next
            assign s_t   = {r_rem[k-1], 1'b0};
            assign s_qin = r_q[k-1];
        end

        assign s_ge  = s_t >= {1'b0, i_den};
        assign s_sub = s_t - {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= s_ge ? s_sub[DW-1:0] : s_t[DW-1:0];
                r_q[k]   <= s_ge ? (s_qin | (17'd1 << I)) : s_qin;
            end
        end
    end

    assign o_quot = r_q[16];

endmodule

// ===== src/alt_sqrt.sv =====
// Digit-by-digit square root, one root bit per stage: floor(sqrt(n)), n <= 2^32.
module alt_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_n,
    output logic [16:0] o_root
);

    logic [32:0] r_rem [17];
    logic [16:0] r_q   [17];

    for (genvar k = 0; k < 17; k++) begin : g_stage
        localparam int I = 16 - k;
        logic [32:0] s_rin;
        logic [16:0] s_qin;
        logic [34:0] s_trial;
        logic [34:0] s_diff;
        logic        s_ge;

        if (k == 0) begin : g_first
            assign s_rin = i_n;
            assign s_qin = '0;
        end else begin : g_next
            assign s_rin = r_rem[k-1];
            assign s_qin = r_q[k-1];
        end

        // (q + 2^I)^2 - q^2 = q * 2^(I+1) + 2^(2I)
        assign s_trial = (35'(s_qin) << (I + 1)) + (35'd1 << (2 * I));
        assign s_ge    = {2'b00, s_rin} >= s_trial;
        assign s_diff  = {2'b00, s_rin} - s_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= s_ge ? s_diff[32:0] : s_rin;
                r_q[k]   <= s_ge ? (s_qin | (17'd1 << I)) : s_qin;
            end
        end
    end

    assign o_root = r_q[16];

endmodule

// ===== src/alt_back.sv =====
module alt_back #(
    parameter int DW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alt_pkg::t_cfg     i_cfg,
    input  logic [DW-1:0]     i_den,
    input  logic              i_q_empty,
    input  logic [2*DW+1:0]   i_q_data,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_red_out,
    output logic [7:0]        o_green_out,
    output logic [7:0]        o_blue_out
);

    localparam int NST = 49;

    logic [NST-1:0] r_vld;
    logic           s_adv;

    logic [16:0]    s_qu;
    logic [16:0]    s_qv;
    logic [16:0]    s_su;
    logic [16:0]    s_cv;

    logic           r_dif1  [17];
    logic           r_dif2  [18];
    alt_pkg::t_q    r_uvm   [18];
    logic [32:0]    r_nu;
    logic [32:0]    r_nv;

    alt_pkg::t_q    r_pp;
    alt_pkg::t_q    r_uvm35;
    logic           r_dif35;
    alt_pkg::t_q    r_ct    [9];
    alt_pkg::t_q    r_s;
    alt_pkg::t_q    r_s2;
    alt_pkg::t_q    r_s4;
    alt_pkg::t_q    r_s8;
    alt_pkg::t_q    r_s16;
    alt_pkg::t_q    r_s8a;
    alt_pkg::t_q    r_s32;
    alt_pkg::t_q    r_s8b;
    alt_pkg::t_q    r_p;
    alt_pkg::t_q    r_spec;

    alt_pkg::t_q    s_chq   [3];
    alt_pkg::t_q    s_aq;
    alt_pkg::t_q    r_bs    [3];
    alt_pkg::t_q    r_cc    [3];
    alt_pkg::t_q    r_bs2   [3];
    alt_pkg::t_q    r_dd    [3];
    alt_pkg::t_q    r_sum   [3];
    alt_pkg::t_q    r_val   [3];
    logic [7:0]     r_out   [3];

    // The whole pipeline moves together unless the output register is held.
    assign s_adv   = !(r_vld[NST-1] && i_stall);
    assign o_pop   = s_adv && !i_q_empty;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_adv) begin
            r_vld <= {r_vld[NST-2:0], !i_q_empty};
        end
    end

    alt_div #(.DW(DW)) u_div_u (
        .i_clk  (i_clk),
        .i_en   (s_adv),
        .i_num  (i_q_data[DW-1:0]),
        .i_den  (i_den),
        .o_quot (s_qu)
    );

    alt_div #(.DW(DW)) u_div_v (
        .i_clk  (i_clk),
        .i_en   (s_adv),
        .i_num  (i_q_data[2*DW-1:DW]),
        .i_den  (i_den),
        .o_quot (s_qv)
    );

    alt_sqrt u_sqrt_u (
        .i_clk  (i_clk),
        .i_en   (s_adv),
        .i_n    (r_nu),
        .o_root (s_su)
    );

    alt_sqrt u_sqrt_v (
        .i_clk  (i_clk),
        .i_en   (s_adv),
        .i_n    (r_nv),
        .o_root (s_cv)
    );

    assign s_chq[0] = alt_pkg::chan_q(i_cfg.tint_red);
    assign s_chq[1] = alt_pkg::chan_q(i_cfg.tint_green);
    assign s_chq[2] = alt_pkg::chan_q(i_cfg.tint_blue);
    assign s_aq     = alt_pkg::chan_q(i_cfg.tint_alpha);

    always_ff @(posedge i_clk) begin
        if (s_adv) begin
            // Signs of u and v differ: the u*v term adds to the base.
            r_dif1[0] <= i_q_data[2*DW] ^ i_q_data[2*DW+1];
            for (int j = 1; j < 17; j++) begin
                r_dif1[j] <= r_dif1[j-1];
            end

            r_nu      <= alt_pkg::circ_arg(alt_pkg::qmul(18'(s_qu), 18'(s_qu)));
            r_nv      <= alt_pkg::circ_arg(alt_pkg::qmul(18'(s_qv), 18'(s_qv)));
            r_uvm[0]  <= alt_pkg::qmul(18'(s_qu), 18'(s_qv));
            r_dif2[0] <= r_dif1[16];
            for (int j = 1; j < 18; j++) begin
                r_uvm[j]  <= r_uvm[j-1];
                r_dif2[j] <= r_dif2[j-1];
            end

            r_pp    <= alt_pkg::qmul(18'(s_su), 18'(s_cv));
            r_uvm35 <= r_uvm[17];
            r_dif35 <= r_dif2[17];
            r_ct[0] <= 18'(s_cv);
            for (int j = 1; j < 9; j++) begin
                r_ct[j] <= r_ct[j-1];
            end

            r_s    <= alt_pkg::spec_base(r_pp, r_uvm35, r_dif35);
            r_s2   <= alt_pkg::qmul(r_s, r_s);
            r_s4   <= alt_pkg::qmul(r_s2, r_s2);
            r_s8   <= alt_pkg::qmul(r_s4, r_s4);
            r_s16  <= alt_pkg::qmul(r_s8, r_s8);
            r_s8a  <= r_s8;
            r_s32  <= alt_pkg::qmul(r_s16, r_s16);
            r_s8b  <= r_s8a;
            r_p    <= alt_pkg::qmul(r_s32, r_s8b);
            r_spec <= alt_pkg::qmul(r_p, alt_pkg::K_SPEC);

            for (int c = 0; c < 3; c++) begin
                r_bs[c]  <= alt_pkg::qmul(i_cfg.metal_mode ? s_chq[c] : alt_pkg::ONE_Q,
                                          r_spec);
                r_cc[c]  <= alt_pkg::qmul(s_chq[c], r_ct[8]);
                r_dd[c]  <= alt_pkg::qmul(r_cc[c], alt_pkg::K_DIFF);
                r_bs2[c] <= r_bs[c];
                r_sum[c] <= r_bs2[c] + r_dd[c];
                r_val[c] <= alt_pkg::qmul(r_sum[c], s_aq);
                r_out[c] <= alt_pkg::scale8(r_val[c]);
            end
        end
    end

    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];

endmodule

// ===== src/aniso_lookup_texel_generator_unit.sv =====
// Channel   Direction  Handshake            Payload
// texel     in         i_valid / o_stall    i_texel_x, i_texel_y
// texel     out        o_valid / i_stall    o_red_out, o_green_out, o_blue_out, o_alpha_out
// config    in         i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// One texel enters and one leaves per cycle unless stalled. A result is presented after
// the front register, the queue and 49 back stages (two 17-stage dividers and two
// 17-stage square roots among them) and can be taken at the following edge.
// Reset is synchronous, active low; it empties the pipeline and queue and loads
// the register defaults. An output stall freezes the back pipeline; the queue then
// fills and the front stalls its input.
`include "aniso_lookup_texel_generator_unit_macros.svh"

module aniso_lookup_texel_generator_unit #(
    parameter int MAX_TEX_SIZE = alt_pkg::MAX_TEX_SIZE_DEF,
    parameter int Q_DEPTH      = alt_pkg::Q_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [9:0]  i_texel_x,
    input  logic [9:0]  i_texel_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_alpha_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    localparam int DW = $clog2(MAX_TEX_SIZE);
    localparam int QW = 2 * DW + 2;

    alt_pkg::t_cfg r_cfg;

    logic          s_push;
    logic          s_pop;
    logic          s_full;
    logic          s_empty;
    logic [DW-1:0] s_den;
    logic [DW-1:0] s_mu;
    logic [DW-1:0] s_mv;
    logic          s_uneg;
    logic          s_vneg;
    logic [QW-1:0] s_qdata;

    assign o_cfg_ready = 1'b1;
    assign o_alpha_out = 8'hFF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.texture_size <= 11'd128;
            r_cfg.tint_red     <= 8'd255;
            r_cfg.tint_green   <= 8'd255;
            r_cfg.tint_blue    <= 8'd255;
            r_cfg.tint_alpha   <= 8'd128;
            r_cfg.metal_mode   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (alt_pkg::t_reg_idx'(i_cfg_index))
                alt_pkg::REG_TEXTURE_SIZE: r_cfg.texture_size <= i_cfg_data;
                alt_pkg::REG_TINT_RED:     r_cfg.tint_red     <= i_cfg_data[7:0];
                alt_pkg::REG_TINT_GREEN:   r_cfg.tint_green   <= i_cfg_data[7:0];
                alt_pkg::REG_TINT_BLUE:    r_cfg.tint_blue    <= i_cfg_data[7:0];
                alt_pkg::REG_TINT_ALPHA:   r_cfg.tint_alpha   <= i_cfg_data[7:0];
                alt_pkg::REG_METAL_MODE:   r_cfg.metal_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    alt_front #(.MAX_TEX_SIZE(MAX_TEX_SIZE), .DW(DW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_texel_x (i_texel_x),
        .i_texel_y (i_texel_y),
        .i_full    (s_full),
        .o_push    (s_push),
        .o_den     (s_den),
        .o_mu      (s_mu),
        .o_mv      (s_mv),
        .o_uneg    (s_uneg),
        .o_vneg    (s_vneg)
    );

    alt_queue #(.W(QW), .DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  ({s_vneg, s_uneg, s_mv, s_mu}),
        .i_pop   (s_pop),
        .o_data  (s_qdata),
        .o_empty (s_empty),
        .o_full  (s_full)
    );

    alt_back #(.DW(DW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_den       (s_den),
        .i_q_empty   (s_empty),
        .i_q_data    (s_qdata),
        .o_pop       (s_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

    `ALT_ASSERT_NOW(a_stall_only_when_full, o_stall, s_full, "input stalled with room in the queue")
    `ALT_ASSERT_NEXT(a_full_holds_on_stall, o_valid && i_stall && s_full, s_full, "queue drained while output held")
    `ALT_ASSERT_NOW(a_no_pop_on_stall, o_valid && i_stall, !s_pop, "queue popped while output held")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_texel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [9:0]  i_texel_x = '0;
    logic [9:0]  i_texel_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red_out;
    logic [7:0]  o_green_out;
    logic [7:0]  o_blue_out;
    logic [7:0]  o_alpha_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    // Local copy of the block's register file.
    logic [10:0] tex_size;
    logic [7:0]  tint_r, tint_g, tint_b, tint_a;
    logic        metal;

    t_texel texel_q[$];
    int     err_cnt = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_cycles = 0;

    aniso_lookup_texel_generator_unit u_top (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("[aniso_lookup_texel_generator_unit] ERROR");
        $finish;
    end

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 16;
    endfunction

    function automatic logic [63:0] fx_sqrt(input logic [63:0] n);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] circle_of(input logic [63:0] a);
        logic [63:0] a2;
        a2 = fx_mul(a, a);
        if (a2 > 65536) a2 = 65536;
        return fx_sqrt((65536 - a2) << 16);
    endfunction

    function automatic logic [63:0] tint_to_fx(input logic [7:0] t);
        return (64'(t) * 65536 + 127) / 255;
    endfunction

    function automatic logic [7:0] shade_channel(input logic [7:0] t, input logic [63:0] spec,
                                                 input logic [63:0] cterm, input logic [63:0] aq);
        logic [63:0] c, base, val;
        c    = tint_to_fx(t);
        base = metal ? c : 64'd65536;
        val  = fx_mul(base, spec) + fx_mul(fx_mul(c, cterm), 64'd13107);
        val  = fx_mul(val, aq);
        if (val > 65536) val = 65536;
        return 8'((val * 255) >> 16);
    endfunction

    function automatic t_texel shade_texel(input logic [9:0] tx, input logic [9:0] ty);
        logic [63:0] sz, d, x, y, um, vm, su, cterm, uvm, s, s8, s32, spec, aq;
        logic        uneg, vneg;
        longint      sb;
        t_texel      r;
        sz = tex_size;
        if (sz < 2) sz = 2;
        if (sz > alt_pkg::MAX_TEX_SIZE_DEF) sz = alt_pkg::MAX_TEX_SIZE_DEF;
        d = sz - 1;
        x = (tx > d) ? d : tx;
        y = (ty > d) ? d : ty;
        uneg = (2 * x) < d;
        um   = uneg ? (d - 2 * x) : (2 * x - d);
        um   = (um << 16) / d;
        vneg = (2 * y) > d;
        vm   = vneg ? (2 * y - d) : (d - 2 * y);
        vm   = (vm << 16) / d;
        if (um > 65536) um = 65536;
        if (vm > 65536) vm = 65536;
        su    = circle_of(um);
        cterm = circle_of(vm);
        uvm   = fx_mul(um, vm);
        sb    = longint'(fx_mul(su, cterm));
        sb    = (uneg != vneg) ? sb + longint'(uvm) : sb - longint'(uvm);
        if (sb < 0) sb = 0;
        if (sb > 65536) sb = 65536;
        s   = sb;
        s   = fx_mul(s, s);
        s   = fx_mul(s, s);
        s8  = fx_mul(s, s);
        s32 = fx_mul(fx_mul(s8, s8), fx_mul(s8, s8));
        spec = fx_mul(fx_mul(s32, s8), 64'd52429);
        aq    = tint_to_fx(tint_a);
        r.red   = shade_channel(tint_r, spec, cterm, aq);
        r.green = shade_channel(tint_g, spec, cterm, aq);
        r.blue  = shade_channel(tint_b, spec, cterm, aq);
        r.alpha = 8'd255;
        return r;
    endfunction

    // Receiver stall and result checking.
    always @(posedge i_clk) begin
        t_texel exp_t;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (texel_q.size() == 0) begin
                $error("result with no expectation waiting");
                err_cnt++;
            end else begin
                exp_t = texel_q.pop_front();
                if (o_red_out !== exp_t.red) begin
                    $error("red_out expected %0d actual %0d", exp_t.red, o_red_out);
                    err_cnt++;
                end
                if (o_green_out !== exp_t.green) begin
                    $error("green_out expected %0d actual %0d", exp_t.green, o_green_out);
                    err_cnt++;
                end
                if (o_blue_out !== exp_t.blue) begin
                    $error("blue_out expected %0d actual %0d", exp_t.blue, o_blue_out);
                    err_cnt++;
                end
                if (o_alpha_out !== exp_t.alpha) begin
                    $error("alpha_out expected %0d actual %0d", exp_t.alpha, o_alpha_out);
                    err_cnt++;
                end
            end
        end
    end

    // Valid stays up after a transaction; the next send or a drain decides what follows.
    task automatic send_texel(input logic [9:0] tx, input logic [9:0] ty);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_texel_x <= tx;
        i_texel_y <= ty;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        texel_q.push_back(shade_texel(tx, ty));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (texel_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input alt_pkg::t_reg_idx idx, input logic [10:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            alt_pkg::REG_TEXTURE_SIZE: tex_size = data;
            alt_pkg::REG_TINT_RED:     tint_r = data[7:0];
            alt_pkg::REG_TINT_GREEN:   tint_g = data[7:0];
            alt_pkg::REG_TINT_BLUE:    tint_b = data[7:0];
            alt_pkg::REG_TINT_ALPHA:   tint_a = data[7:0];
            default:                   metal = data[0];
        endcase
    endtask

    task automatic set_all(input logic [10:0] sz, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic [7:0] a, input logic m);
        drain();
        write_reg(alt_pkg::REG_TEXTURE_SIZE, sz);
        write_reg(alt_pkg::REG_TINT_RED, 11'(r));
        write_reg(alt_pkg::REG_TINT_GREEN, 11'(g));
        write_reg(alt_pkg::REG_TINT_BLUE, 11'(b));
        write_reg(alt_pkg::REG_TINT_ALPHA, 11'(a));
        write_reg(alt_pkg::REG_METAL_MODE, 11'(m));
        i_cfg_valid <= 1'b0;
    endtask

    // Corners, center, out-of-range coordinates and the size clamps.
    task automatic test_directed();
        send_texel(0, 0);
        send_texel(127, 127);
        send_texel(64, 63);
        send_texel(0, 127);
        send_texel(1023, 1023);
        send_texel(1023, 0);
        set_all(11'd0, 8'd255, 8'd0, 8'd128, 8'd255, 1'b1);
        send_texel(0, 0);
        send_texel(1, 1);
        send_texel(1023, 5);
        set_all(11'd2047, 8'd0, 8'd255, 8'd1, 8'd0, 1'b0);
        send_texel(512, 511);
        send_texel(1023, 0);
        set_all(11'd1024, 8'd200, 8'd100, 8'd50, 8'd255, 1'b1);
        send_texel(0, 1023);
        send_texel(511, 512);
        send_texel(1023, 1023);
        send_texel(682, 341);
    endtask

    task automatic test_random(input int n);
        logic [10:0] sz;
        logic [9:0]  tx, ty;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                case ($urandom_range(3))
                    0:       sz = 11'($urandom_range(2047));
                    1:       sz = 11'($urandom_range(1024, 2));
                    2:       sz = 11'($urandom_range(2));
                    default: sz = 11'($urandom_range(64, 2));
                endcase
                set_all(sz, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        1'($urandom));
            end
            // Mostly coordinates inside the texture, a few saturating ones.
            if ($urandom_range(9) == 0) begin
                tx = 10'($urandom);
                ty = 10'($urandom);
            end else begin
                tx = 10'($urandom_range((tex_size < 2 ? 2 : tex_size) - 1));
                ty = 10'($urandom_range((tex_size < 2 ? 2 : tex_size) - 1));
            end
            send_texel(tx, ty);
        end
    endtask

    // Long output stall fills the pipeline, then the sender waits for all results.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 200;
        for (int i = 0; i < 80; i++) send_texel(10'($urandom), 10'($urandom));
        drain();
        for (int i = 0; i < 20; i++) send_texel(10'($urandom), 10'($urandom));
    endtask

    initial begin
        tex_size = 11'd128;
        tint_r = 8'd255;
        tint_g = 8'd255;
        tint_b = 8'd255;
        tint_a = 8'd128;
        metal = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 31;
        recv_idle_pct = 73;
        test_random(600);
        send_idle_pct = 73;
        recv_idle_pct = 31;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(550);
        test_backpressure();
        drain();
        if (err_cnt == 0) begin
            $display("[aniso_lookup_texel_generator_unit] OK");
        end else begin
            $display("[aniso_lookup_texel_generator_unit] ERROR");
        end
        $finish;
    end
endmodule
